### rtl/spc_pkg.sv
// spc_pkg: shared widths, operation codes, state type and structs for the
// sprite pixel collision block. No dependencies.
`default_nettype none
package spc_pkg;

   localparam int MAX_SIDE = 32;
   localparam int SIDE_W   = 6;
   localparam int COORD_W  = 10;
   localparam int ADDR_W   = 10;
   localparam int CHAR_W   = 8;
   localparam int OP_W     = 2;

   localparam logic [CHAR_W-1:0] TRANSPARENT_CHAR = 8'h20;

   localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
   localparam logic [OP_W-1:0] OP_TEST   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_left;
      logic signed [COORD_W-1:0] a_top;
      logic [SIDE_W-1:0]         a_width;
      logic [SIDE_W-1:0]         a_height;
      logic signed [COORD_W-1:0] b_left;
      logic signed [COORD_W-1:0] b_top;
      logic [SIDE_W-1:0]         b_width;
      logic [SIDE_W-1:0]         b_height;
   } geom_type;

   typedef struct packed {
      logic              in_b;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
   } cell_type;

   // clamp an oversized side to the maximum
   function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] s);
      logic [SIDE_W-1:0] r;
      r = (s > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : s;
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/sprite_pixel_collision.sv
// sprite_pixel_collision: top level. Sequencer, geometry registers, the two
// mask memories and the result register. Uses spc_pkg, spc_mask_ram,
// spc_cell_unit.
//
// Loads (operation 0 or 1) write one opacity bit of sprite A's or B's
// 1024-entry mask; a character other than space is opaque.
// A test (operation 2) scans sprite A's rectangle column by column, one
// cell per cycle through a single cell evaluator, and stops at the first
// cell where both sprites are opaque. A test of zero width or height scans
// no cell and reports no collision; otherwise each cell is checked from
// the registered mask read that trails the scan, the last cell in ST_DRAIN.
// Sides above 32 clamp to 32. Operation 3 is dropped. The block takes no
// request while a test runs, or while a result waits and is not being
// taken in that cycle; loads and zero-size tests otherwise follow one per
// cycle. Mask entries have no reset value and must be loaded before a test
// reads them.
`default_nettype none
module sprite_pixel_collision (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [spc_pkg::OP_W-1:0]      req_operation,
   input  wire logic [spc_pkg::ADDR_W-1:0]    req_pixel_index,
   input  wire logic [spc_pkg::CHAR_W-1:0]    req_pixel_char,
   input  wire logic signed [spc_pkg::COORD_W-1:0] req_a_left,
   input  wire logic signed [spc_pkg::COORD_W-1:0] req_a_top,
   input  wire logic [spc_pkg::SIDE_W-1:0]    req_a_width,
   input  wire logic [spc_pkg::SIDE_W-1:0]    req_a_height,
   input  wire logic signed [spc_pkg::COORD_W-1:0] req_b_left,
   input  wire logic signed [spc_pkg::COORD_W-1:0] req_b_top,
   input  wire logic [spc_pkg::SIDE_W-1:0]    req_b_width,
   input  wire logic [spc_pkg::SIDE_W-1:0]    req_b_height,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_collides
);
   import spc_pkg::*;

   state_type         state_ff, state_in;
   geom_type          geom_ff, geom_in;
   logic [SIDE_W-1:0] col_ff, col_in, row_ff, row_in;
   logic              look_ff, look_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_collides_ff, rsp_collides_in;

   logic              accept, is_test, zero_size, opaque;
   logic              issue, last_cell, hit, finish, finish_value;
   logic              a_bit, b_bit;
   cell_type          scan_cell;

   // Accept in idle whenever the result register is free or emptying.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_test   = accept && (req_operation == OP_TEST);
   assign opaque    = (req_pixel_char != TRANSPARENT_CHAR);

   always_comb begin
      geom_in.a_left   = req_a_left;
      geom_in.a_top    = req_a_top;
      geom_in.a_width  = sat_side(req_a_width);
      geom_in.a_height = sat_side(req_a_height);
      geom_in.b_left   = req_b_left;
      geom_in.b_top    = req_b_top;
      geom_in.b_width  = sat_side(req_b_width);
      geom_in.b_height = sat_side(req_b_height);
   end

   assign zero_size = (geom_in.a_width == '0) || (geom_in.a_height == '0);

   spc_cell_unit u_cell (
      .geom      (geom_ff),
      .col       (col_ff),
      .row       (row_ff),
      .scan_cell (scan_cell)
   );

   assign issue = (state_ff == ST_SCAN);

   spc_mask_ram #(.ADDR_BITS(ADDR_W)) u_mask_a (
      .clock   (clock),
      .wr_en   (accept && (req_operation == OP_LOAD_A)),
      .wr_addr (req_pixel_index),
      .wr_data (opaque),
      .rd_en   (issue),
      .rd_addr (scan_cell.addr_a),
      .rd_data (a_bit)
   );

   spc_mask_ram #(.ADDR_BITS(ADDR_W)) u_mask_b (
      .clock   (clock),
      .wr_en   (accept && (req_operation == OP_LOAD_B)),
      .wr_addr (req_pixel_index),
      .wr_data (opaque),
      .rd_en   (issue),
      .rd_addr (scan_cell.addr_b),
      .rd_data (b_bit)
   );

   // The read data belongs to the cell issued in the previous cycle.
   assign hit       = look_ff && a_bit && b_bit;
   assign last_cell = (col_ff == geom_ff.a_width - SIDE_W'(1))
                      && (row_ff == geom_ff.a_height - SIDE_W'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_test && !zero_size) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (hit) begin
               state_in = ST_IDLE;
            end else if (last_cell) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: scan position, read tracking and the result.
   always_comb begin
      finish       = 1'b0;
      finish_value = 1'b0;
      col_in       = col_ff;
      row_in       = row_ff;
      unique case (state_ff)
         ST_IDLE: begin
            col_in = '0;
            row_in = '0;
            if (is_test && zero_size) begin
               finish = 1'b1;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               finish       = 1'b1;
               finish_value = 1'b1;
            end
            // advance down the column, then to the next column
            if (row_ff == geom_ff.a_height - SIDE_W'(1)) begin
               row_in = '0;
               col_in = col_ff + SIDE_W'(1);
            end else begin
               row_in = row_ff + SIDE_W'(1);
            end
         end
         ST_DRAIN: begin
            finish       = 1'b1;
            finish_value = hit;
         end
         default: begin
            finish = 1'b0;
         end
      endcase

      look_in = issue && scan_cell.in_b;

      // hold the result until taken; a new one lands only in a free slot
      priority if (finish) begin
         rsp_valid_in    = 1'b1;
         rsp_collides_in = finish_value;
      end else begin
         rsp_valid_in    = rsp_valid_ff && !rsp_ready;
         rsp_collides_in = rsp_collides_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         look_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         look_ff      <= look_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_test) begin
         geom_ff <= geom_in;
      end
      col_ff          <= col_in;
      row_ff          <= row_in;
      rsp_collides_ff <= rsp_collides_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_collides = rsp_collides_ff;

`ifndef SYNTHESIS
   // The result slot stays free for the whole scan.
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> !rsp_valid_ff)
      else $error("result register busy during a scan");

   // The scan position never leaves sprite A's rectangle.
   a_in_rect: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |->
         (col_ff < geom_ff.a_width) && (row_ff < geom_ff.a_height))
      else $error("scan position outside sprite A");

   // A new result follows an accepted test or the end of a scan.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready)) |->
         ($past(is_test) || $past(state_ff) != ST_IDLE))
      else $error("result without a test");
`endif

endmodule
`default_nettype wire

### rtl/spc_mask_ram.sv
// spc_mask_ram: one-bit-wide opacity mask memory, one write and one
// registered read per cycle. No dependencies.
`default_nettype none
module spc_mask_ram #(
   parameter int ADDR_BITS = 10
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic                 wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic                      rd_data
);

   logic mem [2**ADDR_BITS];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/spc_cell_unit.sv
// spc_cell_unit: shared cell evaluator. For one cell of sprite A's rectangle
// it tests overlap with sprite B and forms both mask addresses. Uses spc_pkg.
`default_nettype none
module spc_cell_unit (
   input  spc_pkg::geom_type              geom,
   input  wire logic [spc_pkg::SIDE_W-1:0] col,
   input  wire logic [spc_pkg::SIDE_W-1:0] row,
   output spc_pkg::cell_type              scan_cell
);
   import spc_pkg::*;

   localparam int PROD_W = 2 * SIDE_W;

   logic signed [COORD_W:0] sx, sy, bx, by, bx_end, by_end, dx, dy;
   logic                    in_x, in_y;
   logic [PROD_W-1:0]       prod_a, prod_b, sum_a, sum_b;

   always_comb begin
      sx     = {geom.a_left[COORD_W-1], geom.a_left}
               + $signed({{(COORD_W+1-SIDE_W){1'b0}}, col});
      sy     = {geom.a_top[COORD_W-1], geom.a_top}
               + $signed({{(COORD_W+1-SIDE_W){1'b0}}, row});
      bx     = {geom.b_left[COORD_W-1], geom.b_left};
      by     = {geom.b_top[COORD_W-1], geom.b_top};
      bx_end = bx + $signed({{(COORD_W+1-SIDE_W){1'b0}}, geom.b_width});
      by_end = by + $signed({{(COORD_W+1-SIDE_W){1'b0}}, geom.b_height});
      in_x   = (sx >= bx) && (sx < bx_end);
      in_y   = (sy >= by) && (sy < by_end);
      dx     = sx - bx;
      dy     = sy - by;

      // offsets into B are below MAX_SIDE whenever the cell is inside B
      prod_a = PROD_W'(row) * PROD_W'(geom.a_width);
      prod_b = PROD_W'(dy[SIDE_W-1:0]) * PROD_W'(geom.b_width);
      sum_a  = prod_a + PROD_W'(col);
      sum_b  = prod_b + PROD_W'(dx[SIDE_W-1:0]);

      scan_cell.in_b   = in_x && in_y;
      scan_cell.addr_a = sum_a[ADDR_W-1:0];
      scan_cell.addr_b = sum_b[ADDR_W-1:0];
   end

endmodule
`default_nettype wire
